[design/spx_pkg.sv]
// Shared types, constants and a helper function of the sprite entry tile expander.
package spx_pkg;

  // One sprite attribute entry plus the priority pass being drawn.
  typedef struct packed {
    logic [15:0] sprite_word0;
    logic [15:0] sprite_word1;
    logic [15:0] sprite_word2;
    logic [15:0] sprite_word3;
    logic        pass_priority;
  } in_t;

  // One tile placement.
  typedef struct packed {
    logic [11:0]        tile_code;
    logic [3:0]         tile_color;
    logic signed [11:0] pos_x;
    logic signed [11:0] pos_y;
    logic               mirror_x;
    logic               mirror_y;
    logic               is_zoomed;
    logic [4:0]         step_x;
    logic [4:0]         step_y;
    logic               last_tile;
  } out_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_FLIP_SCREEN = 2'd0,
    CFG_MAX_X       = 2'd1,
    CFG_MAX_Y       = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_t;

  localparam int unsigned CFG_DATA_W = 9;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic prep;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic drop;
    logic last;
  } stat_t;

  // Position bias, flip-screen adjustments and wrap offset.
  localparam logic signed [11:0] X_BIAS      = 12'sd13;
  localparam logic signed [11:0] Y_BIAS      = 12'sd6;
  localparam logic signed [11:0] FLIP_X_ADJ  = 12'sd24;
  localparam logic signed [11:0] FLIP_Y_ADJ  = 12'sd4;
  localparam logic signed [11:0] WRAP_OFFSET = 12'sd512;

  localparam logic [8:0] RESET_MAX_X = 9'd255;
  localparam logic [8:0] RESET_MAX_Y = 9'd223;

  // Zoom shrink table, indexed by the four-bit zoom index.
  localparam logic [7:0] ZOOM_TABLE [16] = '{
    8'd0,  8'd7,  8'd14, 8'd20, 8'd25, 8'd30, 8'd34, 8'd38,
    8'd42, 8'd46, 8'd49, 8'd52, 8'd54, 8'd57, 8'd59, 8'd61
  };

  // Tile pitch in pixels for a zoom index: 16 minus an eighth of the shrink.
  function automatic logic [4:0] zoom_step(input logic [3:0] idx);
    logic [7:0] shrink;
    shrink = ZOOM_TABLE[idx];
    return 5'd16 - {2'b00, shrink[5:3]};
  endfunction

endpackage

[design/sprite_entry_tile_expander_top.sv]
// Top level of the sprite entry tile expander.
// A request is taken when start is high while busy is low. The block then spends a
// setup state decoding the entry, and for an enabled entry of the current priority
// emits one tile placement per cycle, row by row, from the tile counters of the
// datapath; an entry of xtiles by ytiles tiles keeps busy high through setup and the
// emission of its placements, a dropped entry through setup alone. Each placement appears on
// result for exactly one cycle with strobe high, one cycle after it is formed, and
// the receiver must take it then. Configuration writes take effect at once and are
// only to be made while busy is low and no placement is still due.
module sprite_entry_tile_expander_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  spx_pkg::in_t                   entry,
  output logic                           strobe,
  output spx_pkg::out_t                  result,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [spx_pkg::CFG_DATA_W-1:0] cfg_data
);
  import spx_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer.
  spx_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Decode, position math and tile walk.
  spx_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .entry     (entry),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result),
    .strobe    (strobe)
  );

endmodule

[design/spx_ctrl.sv]
// Controller state machine of the sprite entry tile expander.
module spx_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  spx_pkg::stat_t stat,
  output spx_pkg::cmd_t  cmd,
  output logic          busy
);
  import spx_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep = 1'b1;
        if (stat.drop) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (stat.last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

[design/spx_dp.sv]
// Datapath of the sprite entry tile expander: registers, position math and tile counters.
module spx_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [spx_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  spx_pkg::in_t                    entry,
  input  spx_pkg::cmd_t                   cmd,
  output spx_pkg::stat_t                  stat,
  output spx_pkg::out_t                   result,
  output logic                            strobe
);
  import spx_pkg::*;

  // Configuration registers.
  logic       flip_screen;
  logic [8:0] max_x;
  logic [8:0] max_y;

  // Latched entry.
  in_t ent;

  // Per-sprite values set up before emission.
  logic signed [11:0] base_x;
  logic signed [11:0] base_y;
  logic [4:0]         sx;
  logic [4:0]         sy;
  logic               mx;
  logic               my;
  logic               zoomed;
  logic [2:0]         xn;
  logic [2:0]         yn;
  logic [3:0]         color;
  logic [11:0]        code;

  // Tile counters.
  logic [2:0] xt;
  logic [2:0] yt;

  // Setup arithmetic.
  logic signed [11:0] x0, y0, x1, y1, x2, y2;
  logic signed [11:0] lim_x, lim_y;
  logic [3:0]         xtiles, ytiles;
  logic               flip_x_in, flip_y_in;

  // Emission arithmetic.
  logic [2:0]         col, row;
  logic [7:0]         off_x, off_y;
  logic signed [11:0] px, py;

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      flip_screen <= 1'b0;
      max_x       <= RESET_MAX_X;
      max_y       <= RESET_MAX_Y;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FLIP_SCREEN: flip_screen <= cfg_data[0];
        CFG_MAX_X:       max_x       <= cfg_data[8:0];
        CFG_MAX_Y:       max_y       <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // A disabled entry or one of the other priority produces nothing.
  assign stat.drop = !ent.sprite_word2[7] || (ent.sprite_word2[4] != ent.pass_priority);
  assign stat.last = (xt == xn) && (yt == yn);

  // Bias, wrap past the visible edge, and mirror under flip-screen.
  always_comb begin
    lim_x     = $signed({3'b000, max_x});
    lim_y     = $signed({3'b000, max_y});
    xtiles    = {1'b0, ent.sprite_word2[10:8]} + 4'd1;
    ytiles    = {1'b0, ent.sprite_word2[14:12]} + 4'd1;
    flip_x_in = ent.sprite_word2[11];
    flip_y_in = ent.sprite_word2[15];
    x0 = $signed({3'b000, ent.sprite_word1[8:0]}) - X_BIAS;
    y0 = $signed({3'b000, ent.sprite_word0[8:0]}) - Y_BIAS;
    x1 = (x0 > lim_x) ? (x0 - WRAP_OFFSET) : x0;
    y1 = (y0 > lim_y) ? (y0 - WRAP_OFFSET) : y0;
    if (flip_screen) begin
      x2 = lim_x - x1 - $signed({4'b0000, xtiles, 4'b0000}) - FLIP_X_ADJ;
      y2 = lim_y - y1 - $signed({4'b0000, ytiles, 4'b0000}) - FLIP_Y_ADJ;
    end else begin
      x2 = x1;
      y2 = y1;
    end
  end

  // Position of the current tile within the grid; offsets reach 7 * 16 pixels.
  always_comb begin
    col   = mx ? (xn - xt) : xt;
    row   = my ? (yn - yt) : yt;
    off_x = {5'b00000, col} * {3'b000, sx};
    off_y = {5'b00000, row} * {3'b000, sy};
    px    = base_x + $signed({4'b0000, off_x});
    py    = base_y + $signed({4'b0000, off_y});
  end

  // Entry latch, per-sprite setup and tile walk.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ent <= entry;
    end
    if (cmd.prep) begin
      base_x <= x2;
      base_y <= y2;
      sx     <= zoom_step(ent.sprite_word1[15:12]);
      sy     <= zoom_step(ent.sprite_word0[15:12]);
      mx     <= flip_x_in ^ flip_screen;
      my     <= flip_y_in ^ flip_screen;
      zoomed <= (ent.sprite_word1[15:12] != 4'd0) || (ent.sprite_word0[15:12] != 4'd0);
      xn     <= ent.sprite_word2[10:8];
      yn     <= ent.sprite_word2[14:12];
      color  <= ent.sprite_word2[3:0];
      code   <= ent.sprite_word3[11:0];
      xt     <= 3'd0;
      yt     <= 3'd0;
    end else if (cmd.emit) begin
      code <= code + 12'd1;
      if (xt == xn) begin
        xt <= 3'd0;
        yt <= yt + 3'd1;
      end else begin
        xt <= xt + 3'd1;
      end
    end
  end

  // Result register; the strobe marks it for one cycle.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.tile_code  <= code;
      result.tile_color <= color;
      result.pos_x      <= px;
      result.pos_y      <= py;
      result.mirror_x   <= mx;
      result.mirror_y   <= my;
      result.is_zoomed  <= zoomed;
      result.step_x     <= sx;
      result.step_y     <= sy;
      result.last_tile  <= stat.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
    end
  end

endmodule

[design/spx_chk.sv]
// Port-level checker of the sprite entry tile expander and its bind.
module spx_chk (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          strobe,
  input spx_pkg::out_t result
);

  // An accepted request always occupies the block for the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy did not rise after a request was taken");

  // Placements of one sprite come out on consecutive cycles.
  a_tiles_back_to_back: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last_tile |=> strobe)
    else $error("gap before the final placement of a sprite");

  // While placements are still due, the block stays busy.
  a_busy_until_last: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last_tile |-> busy)
    else $error("busy dropped before the final placement");

  // The tile code steps by one modulo 4096 within a sprite.
  a_code_step: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last_tile |=>
      result.tile_code == 12'($past(result.tile_code) + 12'd1))
    else $error("tile code did not increment");

  // No placement appears out of an idle cycle.
  a_no_stray_result: assert property (@(posedge clk) disable iff (rst)
    !busy |=> !strobe)
    else $error("placement emitted while idle");

endmodule

bind sprite_entry_tile_expander_top spx_chk u_chk (.*);

[test/tb_top.sv]
// Self-checking testbench of the sprite entry tile expander, with its own placement predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spx_pkg::*;

  // Kinds of scheduled driver operations.
  typedef enum {
    OP_ENTRY,
    OP_REG_WRITE,
    OP_SETTLE
  } op_kind_t;

  typedef struct {
    op_kind_t   kind;
    in_t        ent;
    cfg_idx_t   idx;
    logic [8:0] data;
    int         idle_pct;
  } sched_op_t;

  localparam int CYCLE_LIMIT    = 300000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int END_CYCLES     = 80;
  localparam int FORMED_PER_SET = 15;
  localparam int MAX_PRINTED    = 40;

  // Position bias, flip-screen adjustment and wrap distance.
  localparam int X_BIAS_PX   = 13;
  localparam int Y_BIAS_PX   = 6;
  localparam int FLIP_X_PX   = 24;
  localparam int FLIP_Y_PX   = 4;
  localparam int WRAP_PX     = 512;
  localparam int TILE_PX     = 16;

  // Zoom shrink in eighths of a pixel, indexed by zoom index.
  localparam int ZOOM_SHRINK_PX [16] = '{
    0, 7, 14, 20, 25, 30, 34, 38, 42, 46, 49, 52, 54, 57, 59, 61
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  in_t        entry = '0;
  logic       strobe;
  out_t       result;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_FLIP_SCREEN;
  logic [8:0] cfg_data = '0;

  sched_op_t pending_ops[$];
  out_t      placements_due[$];

  // Shadow copies of the configuration registers.
  logic       flip_reg  = 1'b0;
  logic [8:0] max_x_reg = 9'd255;
  logic [8:0] max_y_reg = 9'd223;

  bit accepted = 1'b0;
  int settle_cnt = 0;
  int cycle_cnt = 0;
  int n_errors = 0;
  int n_entries = 0;
  int n_drawn = 0;
  int n_placements = 0;
  int n_reg_writes = 0;

  sprite_entry_tile_expander_top u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .entry     (entry),
    .strobe    (strobe),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Print one mismatch line and count it; printing stops after MAX_PRINTED lines.
  task automatic report_error(input string msg);
    if (n_errors < MAX_PRINTED) begin
      $display("ERROR at cycle %0d: %s", cycle_cnt, msg);
    end
    n_errors++;
  endtask

  // Update the shadow registers the way the block treats a write.
  task automatic apply_reg_write(input logic [1:0] idx, input logic [8:0] data);
    case (idx)
      CFG_FLIP_SCREEN: flip_reg = data[0];
      CFG_MAX_X: max_x_reg = data;
      CFG_MAX_Y: max_y_reg = data;
      default: ;
    endcase
    n_reg_writes++;
  endtask

  // Work out every tile placement that one sprite entry produces.
  task automatic expand_entry(input in_t e);
    logic [3:0] zx, zy;
    logic [4:0] sx, sy;
    logic fx, fy, zoomed;
    logic [11:0] code;
    int x, y, ncols, nrows, col, row, px, py;
    out_t p;
    if (!e.sprite_word2[7] || (e.sprite_word2[4] != e.pass_priority)) return;
    n_drawn++;
    zy = e.sprite_word0[15:12];
    zx = e.sprite_word1[15:12];
    zoomed = (zx != 0) || (zy != 0);
    sx = 5'(TILE_PX - ZOOM_SHRINK_PX[zx] / 8);
    sy = 5'(TILE_PX - ZOOM_SHRINK_PX[zy] / 8);
    ncols = int'(e.sprite_word2[10:8]) + 1;
    nrows = int'(e.sprite_word2[14:12]) + 1;
    fx = e.sprite_word2[11];
    fy = e.sprite_word2[15];
    code = e.sprite_word3[11:0];
    x = int'(e.sprite_word1[8:0]) - X_BIAS_PX;
    y = int'(e.sprite_word0[8:0]) - Y_BIAS_PX;
    // Positions past the visible edge wrap to the negative side.
    if (x > int'(max_x_reg)) x -= WRAP_PX;
    if (y > int'(max_y_reg)) y -= WRAP_PX;
    // Flip screen mirrors the whole sprite and inverts both flips.
    if (flip_reg) begin
      y = int'(max_y_reg) - y - TILE_PX * nrows - FLIP_Y_PX;
      x = int'(max_x_reg) - x - TILE_PX * ncols - FLIP_X_PX;
      fx = ~fx;
      fy = ~fy;
    end
    for (int r = 0; r < nrows; r++) begin
      for (int c = 0; c < ncols; c++) begin
        col = fx ? (ncols - 1 - c) : c;
        row = fy ? (nrows - 1 - r) : r;
        px = x + col * int'(sx);
        py = y + row * int'(sy);
        p.tile_code  = code;
        p.tile_color = e.sprite_word2[3:0];
        p.pos_x      = px[11:0];
        p.pos_y      = py[11:0];
        p.mirror_x   = fx;
        p.mirror_y   = fy;
        p.is_zoomed  = zoomed;
        p.step_x     = sx;
        p.step_y     = sy;
        p.last_tile  = (r == nrows - 1) && (c == ncols - 1);
        placements_due.push_back(p);
        code = code + 12'd1;
      end
    end
  endtask

  // Compare one emitted placement with the oldest one due.
  task automatic check_placement(input out_t got);
    out_t want;
    if (placements_due.size() == 0) begin
      report_error($sformatf("placement with code %0d when none was due", got.tile_code));
      return;
    end
    want = placements_due.pop_front();
    n_placements++;
    if (got.tile_code !== want.tile_code)
      report_error($sformatf("tile_code %0d, want %0d", got.tile_code, want.tile_code));
    if (got.tile_color !== want.tile_color)
      report_error($sformatf("tile_color %0d, want %0d", got.tile_color, want.tile_color));
    if (got.pos_x !== want.pos_x)
      report_error($sformatf("pos_x %0d, want %0d", got.pos_x, want.pos_x));
    if (got.pos_y !== want.pos_y)
      report_error($sformatf("pos_y %0d, want %0d", got.pos_y, want.pos_y));
    if (got.mirror_x !== want.mirror_x)
      report_error($sformatf("mirror_x %0b, want %0b", got.mirror_x, want.mirror_x));
    if (got.mirror_y !== want.mirror_y)
      report_error($sformatf("mirror_y %0b, want %0b", got.mirror_y, want.mirror_y));
    if (got.is_zoomed !== want.is_zoomed)
      report_error($sformatf("is_zoomed %0b, want %0b", got.is_zoomed, want.is_zoomed));
    if (got.step_x !== want.step_x)
      report_error($sformatf("step_x %0d, want %0d", got.step_x, want.step_x));
    if (got.step_y !== want.step_y)
      report_error($sformatf("step_y %0d, want %0d", got.step_y, want.step_y));
    if (got.last_tile !== want.last_tile)
      report_error($sformatf("last_tile %0b, want %0b", got.last_tile, want.last_tile));
  endtask

  // Build an entry from its decoded fields; tile counts are given minus one.
  function automatic in_t make_entry(
    input logic [8:0] ypos, input logic [3:0] yzoom,
    input logic [8:0] xpos, input logic [3:0] xzoom,
    input logic [3:0] color, input logic prio, input logic enable,
    input logic [2:0] xn, input logic xflip, input logic [2:0] yn, input logic yflip,
    input logic [11:0] code, input logic pass);
    in_t e;
    e.sprite_word0  = {yzoom, 3'b000, ypos};
    e.sprite_word1  = {xzoom, 3'b000, xpos};
    e.sprite_word2  = {yflip, yn, xflip, xn, enable, 2'b00, prio, color};
    e.sprite_word3  = {4'h0, code};
    e.pass_priority = pass;
    return e;
  endfunction

  // Random entry; a drawable one is enabled and of the current pass.
  function automatic in_t random_entry(input bit drawable);
    in_t e;
    e.sprite_word0  = 16'($urandom);
    e.sprite_word1  = 16'($urandom);
    e.sprite_word2  = 16'($urandom);
    e.sprite_word3  = 16'($urandom);
    e.pass_priority = 1'($urandom);
    if (drawable) begin
      e.sprite_word2[7] = 1'b1;
      e.sprite_word2[4] = e.pass_priority;
    end
    return e;
  endfunction

  task automatic push_entry(input in_t e, input int idle_pct);
    sched_op_t op;
    op.kind = OP_ENTRY;
    op.ent = e;
    op.idx = CFG_FLIP_SCREEN;
    op.data = '0;
    op.idle_pct = idle_pct;
    pending_ops.push_back(op);
  endtask

  task automatic push_reg_write(input cfg_idx_t idx, input logic [8:0] data);
    sched_op_t op;
    op.kind = OP_REG_WRITE;
    op.ent = '0;
    op.idx = idx;
    op.data = data;
    op.idle_pct = 0;
    pending_ops.push_back(op);
  endtask

  task automatic push_settle();
    sched_op_t op;
    op.kind = OP_SETTLE;
    op.ent = '0;
    op.idx = CFG_FLIP_SCREEN;
    op.data = '0;
    op.idle_pct = 0;
    pending_ops.push_back(op);
  endtask

  // Wait for the block to drain, then load all three registers.
  task automatic push_settings(input logic flip, input logic [8:0] mx, input logic [8:0] my);
    push_settle();
    push_reg_write(CFG_FLIP_SCREEN, {8'($urandom), flip});
    push_reg_write(CFG_MAX_X, mx);
    push_reg_write(CFG_MAX_Y, my);
  endtask

  // Monitor: register writes, accepted requests and emitted placements.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", cycle_cnt);
      $display("simulation failed");
      $finish;
    end else if (rst) begin
      accepted = 1'b0;
    end else begin
      if (cfg_we) apply_reg_write(cfg_index, cfg_data);
      accepted = start && !busy;
      if (accepted) begin
        n_entries++;
        expand_entry(entry);
      end
      if (strobe) check_placement(result);
    end
  end

  // Driver: presents scheduled requests and register writes on the falling edge.
  always @(negedge clk) begin : drive
    logic nxt_start;
    logic nxt_we;
    nxt_start = start;
    nxt_we = 1'b0;
    if (!rst && !(start && !accepted)) begin
      nxt_start = 1'b0;
      if (pending_ops.size() > 0) begin
        case (pending_ops[0].kind)
          OP_ENTRY: begin
            if ($urandom_range(99) >= pending_ops[0].idle_pct) begin
              entry <= pending_ops[0].ent;
              nxt_start = 1'b1;
              void'(pending_ops.pop_front());
            end
          end
          OP_REG_WRITE: begin
            cfg_index <= pending_ops[0].idx;
            cfg_data <= pending_ops[0].data;
            nxt_we = 1'b1;
            void'(pending_ops.pop_front());
          end
          default: begin
            // Hold off until every placement is in and the block has been quiet a while.
            if (placements_due.size() == 0 && !busy) begin
              if (settle_cnt >= SETTLE_CYCLES) begin
                settle_cnt = 0;
                void'(pending_ops.pop_front());
              end else begin
                settle_cnt++;
              end
            end else begin
              settle_cnt = 0;
            end
          end
        endcase
      end
    end
    start <= nxt_start;
    cfg_we <= nxt_we;
  end

  // Stimulus schedule, reset and end of run.
  initial begin : stimulus
    logic [8:0] set_x [6];
    logic [8:0] set_y [6];
    logic       set_flip [6];
    int idle_pct;
    int formed;

    // Directed entries at the reset settings.
    idle_pct = 22;
    push_entry(make_entry(9'd0, 4'd0, 9'd0, 4'd0, 4'd0, 1'b0, 1'b1,
                          3'd0, 1'b0, 3'd0, 1'b0, 12'd0, 1'b0), idle_pct);
    push_entry('{16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b1}, idle_pct);
    push_entry('{16'hffff, 16'hffff, 16'hff7f, 16'hffff, 1'b1}, idle_pct);
    push_entry(make_entry(9'd40, 4'd0, 9'd40, 4'd0, 4'd5, 1'b1, 1'b1,
                          3'd1, 1'b0, 3'd1, 1'b0, 12'd10, 1'b0), idle_pct);
    push_entry(make_entry(9'd40, 4'd0, 9'd40, 4'd0, 4'd5, 1'b0, 1'b1,
                          3'd1, 1'b0, 3'd1, 1'b0, 12'd10, 1'b1), idle_pct);
    push_entry(make_entry(9'd100, 4'd0, 9'd100, 4'd0, 4'd15, 1'b1, 1'b1,
                          3'd3, 1'b0, 3'd1, 1'b0, 12'hffc, 1'b1), idle_pct);
    push_entry(make_entry(9'd60, 4'd0, 9'd60, 4'd8, 4'd3, 1'b0, 1'b1,
                          3'd2, 1'b0, 3'd1, 1'b0, 12'd300, 1'b0), idle_pct);
    push_entry(make_entry(9'd60, 4'd15, 9'd60, 4'd0, 4'd3, 1'b0, 1'b1,
                          3'd1, 1'b0, 3'd2, 1'b0, 12'd301, 1'b0), idle_pct);
    push_entry(make_entry(9'd60, 4'd2, 9'd60, 4'd1, 4'd3, 1'b0, 1'b1,
                          3'd1, 1'b0, 3'd1, 1'b0, 12'd302, 1'b0), idle_pct);
    push_entry(make_entry(9'd80, 4'd0, 9'd80, 4'd3, 4'd9, 1'b0, 1'b1,
                          3'd2, 1'b1, 3'd1, 1'b0, 12'd500, 1'b0), idle_pct);
    push_entry(make_entry(9'd80, 4'd5, 9'd80, 4'd0, 4'd9, 1'b0, 1'b1,
                          3'd1, 1'b0, 3'd2, 1'b1, 12'd510, 1'b0), idle_pct);
    push_entry(make_entry(9'd80, 4'd12, 9'd80, 4'd6, 4'd9, 1'b0, 1'b1,
                          3'd2, 1'b1, 3'd2, 1'b1, 12'd520, 1'b0), idle_pct);
    // Just inside and just past the wrap edge on each axis.
    push_entry(make_entry(9'd229, 4'd0, 9'd268, 4'd0, 4'd1, 1'b0, 1'b1,
                          3'd0, 1'b0, 3'd0, 1'b0, 12'd7, 1'b0), idle_pct);
    push_entry(make_entry(9'd230, 4'd0, 9'd269, 4'd0, 4'd1, 1'b0, 1'b1,
                          3'd0, 1'b0, 3'd0, 1'b0, 12'd8, 1'b0), idle_pct);
    push_entry(make_entry(9'd511, 4'd0, 9'd511, 4'd0, 4'd2, 1'b0, 1'b1,
                          3'd7, 1'b0, 3'd0, 1'b0, 12'd20, 1'b0), idle_pct);
    push_entry(make_entry(9'd16, 4'd0, 9'd16, 4'd0, 4'd2, 1'b0, 1'b1,
                          3'd0, 1'b0, 3'd7, 1'b0, 12'd30, 1'b0), idle_pct);

    // Directed entries with the screen flipped.
    push_settings(1'b1, 9'd255, 9'd223);
    push_entry(make_entry(9'd0, 4'd0, 9'd0, 4'd0, 4'd0, 1'b0, 1'b1,
                          3'd0, 1'b0, 3'd0, 1'b0, 12'd0, 1'b0), idle_pct);
    push_entry('{16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b1}, idle_pct);
    push_entry(make_entry(9'd120, 4'd4, 9'd130, 4'd9, 4'd6, 1'b1, 1'b1,
                          3'd2, 1'b1, 3'd1, 1'b0, 12'd900, 1'b1), idle_pct);
    push_entry(make_entry(9'd300, 4'd0, 9'd300, 4'd0, 4'd6, 1'b1, 1'b1,
                          3'd1, 1'b0, 3'd2, 1'b1, 12'd910, 1'b1), idle_pct);

    // A write past the register list changes nothing; flip ignores its upper bits.
    push_settle();
    push_reg_write(CFG_UNUSED, 9'h1ff);
    push_reg_write(CFG_FLIP_SCREEN, 9'h1fe);
    push_entry(make_entry(9'd50, 4'd0, 9'd50, 4'd0, 4'd4, 1'b0, 1'b1,
                          3'd1, 1'b0, 3'd1, 1'b0, 12'd40, 1'b0), idle_pct);

    // Random phases, each under its own register settings.
    set_flip = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
    set_x = '{9'd0, 9'd511, 9'd0, 9'd511, 9'($urandom_range(511)), 9'($urandom_range(511))};
    set_y = '{9'd0, 9'd511, 9'd511, 9'd0, 9'($urandom_range(511)), 9'($urandom_range(511))};
    for (int s = 0; s < 6; s++) begin
      idle_pct = (s < 2) ? 22 : ((s < 4) ? 53 : 0);
      push_settings(set_flip[s], set_x[s], set_y[s]);
      formed = 0;
      while (formed < FORMED_PER_SET) begin
        if ($urandom_range(99) < 20) begin
          push_entry(random_entry(1'b0), idle_pct);
        end else begin
          push_entry(random_entry(1'b1), idle_pct);
          formed++;
        end
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait until every request has been taken and every placement has come.
    while (pending_ops.size() != 0 || start) @(posedge clk);
    while (placements_due.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);

    $display("Covered %0d sprite entries, %0d of them drawn, checking %0d tile placements.",
             n_entries, n_drawn, n_placements);
    $display("Register writes: %0d, across normal and flipped screens and edge limits.",
             n_reg_writes);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
